// ----- rtl/sfla_pkg.sv -----
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int unsigned SFLA_SLOTS = 256;

  localparam int unsigned CFG_W    = 9;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GRANT_W  = 8;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 9'd256;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } sfla_cmd_t;

  typedef struct packed {
    logic out_busy;
  } sfla_sts_t;

endpackage

// ----- rtl/sfla_if.sv -----
`timescale 1ns / 1ps

interface sfla_req_if
  import sfla_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, output req_type, output slot_index, input ready);
  modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

interface sfla_rsp_if
  import sfla_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [GRANT_W-1:0]  granted_slot;

  modport source (output valid, output status, output granted_slot, input ready);
  modport sink   (input valid, input status, input granted_slot, output ready);
endinterface

// ----- rtl/sfla_ctrl.sv -----
`timescale 1ns / 1ps

module sfla_ctrl
  import sfla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sfla_sts_t sts_i,
  output sfla_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.capture = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit  = (state_q == S_EXEC) && !sts_i.out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!sts_i.out_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/sfla_dp.sv -----
`timescale 1ns / 1ps

module sfla_dp
  import sfla_pkg::*;
#(
  parameter int unsigned SLOTS = SFLA_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfla_cmd_t           cmd_i,
  output sfla_sts_t           sts_o,
  input  logic                req_type_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [GRANT_W-1:0]  granted_slot_o
);

  localparam int unsigned IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW  = $clog2(SLOTS + 1);
  localparam int unsigned CWX = (LW > CFG_W) ? LW : CFG_W;
  localparam int unsigned GW  = (IW > IDX_W) ? IW : IDX_W;
  localparam logic [CWX-1:0] SLOTS_C = CWX'(SLOTS);

  logic [CFG_W-1:0]   slot_count_q;
  logic [IW-1:0]      head_q, head_d;
  logic               nonempty_q, nonempty_d;
  logic [IDX_W-1:0]   bump_q, bump_d;
  logic               req_q;
  logic [IDX_W-1:0]   idx_q;
  logic               out_valid_q;
  status_e            out_status_q, status_d;
  logic [GRANT_W-1:0] out_grant_q;
  logic [GW-1:0]      grant_d;
  logic [CWX-1:0]     cfg_ext, eff_count;
  logic               mem_we;
  logic [LW-1:0]      mem_wdata;
  logic [LW-1:0]      link_rd_q;
  logic [LW-1:0]      link_mem [SLOTS];

  assign cfg_ext   = CWX'(slot_count_q);
  assign eff_count = (cfg_ext > SLOTS_C) ? SLOTS_C : cfg_ext;

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign granted_slot_o = out_grant_q;

  always_comb begin
    status_d   = ST_DONE;
    grant_d    = '0;
    head_d     = head_q;
    nonempty_d = nonempty_q;
    bump_d     = bump_q;
    mem_we     = 1'b0;
    mem_wdata  = nonempty_q ? (LW'(head_q) + LW'(1)) : '0;
    if (req_q == REQ_ALLOC) begin
      if (nonempty_q && (CWX'(head_q) < SLOTS_C)) begin
        grant_d = GW'(head_q);
        if (link_rd_q != '0) begin
          head_d     = IW'(link_rd_q - LW'(1));
          nonempty_d = 1'b1;
        end else begin
          head_d     = '0;
          nonempty_d = 1'b0;
        end
      end else if (CWX'(bump_q) < eff_count) begin
        grant_d = GW'(bump_q);
        bump_d  = bump_q + IDX_W'(1);
      end else begin
        status_d = ST_EXHAUSTED;
      end
    end else begin
      if (CWX'(idx_q) >= eff_count) begin
        status_d = ST_RANGE;
      end else begin
        mem_we     = 1'b1;
        head_d     = IW'(idx_q);
        nonempty_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && cmd_i.commit) begin
      link_mem[IW'(idx_q)] <= mem_wdata;
    end
    link_rd_q <= link_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      idx_q <= slot_index_i;
    end
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_grant_q  <= grant_d[GRANT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      bump_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        head_q      <= head_d;
        nonempty_q  <= nonempty_d;
        bump_q      <= bump_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/slot_free_list_allocator_core.sv -----
// Slot allocator: hands out slot numbers from a LIFO free list, falling back
// to a bump counter for never-used slots.
// req_i carries one item per request: req_type (allocate or free) and
// slot_index (the slot to free). rsp_o returns one item per request: status
// (done, pool exhausted, index out of range) and granted_slot.
// cfg_we_i/cfg_wdata_i write slot_count, the number of slots in the pool; write
// it only while no request is in flight.
// An accepted item is captured into registers and moves the control from
// IDLE to EXEC; its result is registered onto rsp_o from EXEC, and a new
// item is taken only once the control is back in IDLE.
// Reset empties the free list, clears the bump counter and sets slot_count
// to 256; the link store is not cleared, no sweep is needed.
// When rsp_o stalls, the result holds and one more item is still taken on
// req_i; it waits inside until the held result is taken.
`timescale 1ns / 1ps

module slot_free_list_allocator_core
  import sfla_pkg::*;
#(
  parameter int unsigned SLOTS = SFLA_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfla_req_if.sink         req_i,
  sfla_rsp_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  sfla_cmd_t cmd;
  sfla_sts_t sts;

  sfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfla_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .slot_index_i   (req_i.slot_index),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .granted_slot_o (rsp_o.granted_slot)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sfla_pkg::*;

  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] slot_index;
  } slot_req_t;

  typedef struct packed {
    status_e            status;
    logic [GRANT_W-1:0] granted_slot;
  } slot_reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  sfla_req_if req_ch ();
  sfla_rsp_if rsp_ch ();

  slot_free_list_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Allocator state as predicted
  logic [CFG_W-1:0]   pool_size;
  logic [GRANT_W-1:0] top_slot;
  logic               top_live;
  logic [IDX_W-1:0]   next_fresh;
  logic [IDX_W-1:0]   slot_link [SFLA_SLOTS];

  slot_req_t   pending_reqs [$];
  slot_reply_t owed_replies [$];
  slot_req_t   drive_req;
  slot_reply_t want;

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int quiet_cycles;
  int items_sent;
  int n_granted;
  int n_exhausted;
  int n_rejected;
  int n_settings;

  function automatic slot_reply_t serve_slot_request(input logic rt,
                                                     input logic [IDX_W-1:0] idx);
    slot_reply_t      r;
    logic [IDX_W-1:0] lim;
    logic [IDX_W-1:0] link;
    lim = (pool_size > SFLA_SLOTS) ? IDX_W'(SFLA_SLOTS) : pool_size;
    r.status = ST_DONE;
    r.granted_slot = '0;
    if (rt == REQ_ALLOC) begin
      if (top_live) begin
        r.granted_slot = top_slot;
        link = slot_link[top_slot];
        if (link != '0) begin
          top_slot = GRANT_W'(link - 1'b1);
        end else begin
          top_slot = '0;
          top_live = 1'b0;
        end
      end else if (next_fresh < lim) begin
        r.granted_slot = next_fresh[GRANT_W-1:0];
        next_fresh = next_fresh + 1'b1;
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else begin
      if (idx >= lim) begin
        r.status = ST_RANGE;
      end else begin
        slot_link[idx[GRANT_W-1:0]] = top_live ? {1'b0, top_slot} + 1'b1 : '0;
        top_slot = idx[GRANT_W-1:0];
        top_live = 1'b1;
      end
    end
    return r;
  endfunction

  always #6 clk_i = ~clk_i;

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        owed_replies.push_back(serve_slot_request(req_ch.req_type, req_ch.slot_index));
        items_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_req = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= drive_req.req_type;
          req_ch.slot_index <= drive_req.slot_index;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_replies.size() == 0) begin
          $display("%0t: unexpected reply status=%0d slot=%0d", $time, rsp_ch.status,
                   rsp_ch.granted_slot);
          errors++;
        end else begin
          want = owed_replies.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_ch.status);
            errors++;
          end
          if (rsp_ch.granted_slot !== want.granted_slot) begin
            $display("%0t: granted_slot expected %0d actual %0d", $time,
                     want.granted_slot, rsp_ch.granted_slot);
            errors++;
          end
          case (want.status)
            ST_DONE:      n_granted++;
            ST_EXHAUSTED: n_exhausted++;
            default:      n_rejected++;
          endcase
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic settle();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_ch.valid || owed_replies.size() != 0)
      @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_slot_count(input logic [CFG_W-1:0] v);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    pool_size = v;
    n_settings++;
  endtask

  task automatic push_req(input logic rt, input logic [IDX_W-1:0] idx);
    slot_req_t r;
    r.req_type   = rt;
    r.slot_index = idx;
    pending_reqs.push_back(r);
  endtask

  // Bursts lean toward allocate or toward free so the list grows and drains
  task automatic queue_random(input int n);
    int        lim;
    int        alloc_pct;
    slot_req_t r;
    lim = (pool_size > SFLA_SLOTS) ? SFLA_SLOTS : pool_size;
    alloc_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 8 == 0) alloc_pct = $urandom_range(1) ? 80 : 25;
      r.slot_index = IDX_W'($urandom_range(511));
      if ($urandom_range(99) < alloc_pct) begin
        r.req_type = REQ_ALLOC;
      end else begin
        r.req_type = REQ_FREE;
        if (lim > 0 && $urandom_range(99) < 85) r.slot_index = IDX_W'($urandom_range(lim - 1));
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cnt, input int send_pct,
                           input int recv_pct, input int n);
    set_slot_count(cnt);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ALLOC;
    req_ch.slot_index = '0;
    rsp_ch.ready      = 1'b0;
    pool_size      = SLOT_COUNT_RST;
    top_slot       = '0;
    top_live       = 1'b0;
    next_fresh     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    quiet_cycles   = 0;
    items_sent     = 0;
    n_granted      = 0;
    n_exhausted    = 0;
    n_rejected     = 0;
    n_settings     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_ALLOC, 9'd511);
    push_req(REQ_FREE, 9'd1);
    push_req(REQ_FREE, 9'd0);
    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_FREE, 9'd255);
    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_FREE, 9'd256);
    push_req(REQ_FREE, 9'd511);
    push_req(REQ_ALLOC, 9'd0);
    set_slot_count(9'd0);
    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_FREE, 9'd0);
    set_slot_count(9'd511);
    push_req(REQ_FREE, 9'd255);
    push_req(REQ_ALLOC, 9'd0);
    set_slot_count(9'd2);
    push_req(REQ_FREE, 9'd1);
    push_req(REQ_FREE, 9'd2);
    push_req(REQ_ALLOC, 9'd0);
    push_req(REQ_ALLOC, 9'd0);

    run_phase(9'd8, 0, 0, 120);
    run_phase(9'd1, 85, 0, 60);
    run_phase(9'd16, 0, 85, 100);
    run_phase(9'd256, 16, 16, 60);
    settle();
    queue_random(60);
    run_phase(9'd0, 0, 0, 20);
    run_phase(9'd511, 0, 0, 80);
    run_phase(9'd5, 16, 16, 80);
    run_phase(9'd200, 85, 0, 70);

    settle();
    repeat (4) @(posedge clk_i);
    $display("covered %0d requests over %0d slot_count settings", items_sent, n_settings);
    $display("replies: %0d done, %0d exhausted, %0d out of range", n_granted, n_exhausted,
             n_rejected);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfla_pkg.sv
rtl/sfla_if.sv
rtl/sfla_ctrl.sv
rtl/sfla_dp.sv
rtl/slot_free_list_allocator_core.sv
tb/tb_top.sv
